@@ rtl/assert_macros.svh @@
// assertion macros shared by the encoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GLE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("gle assertion failed");
`define GLE_NEVER(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
        else $error("gle forbidden condition");
`else
`define GLE_ASSERT(lbl, clk, rst_n, prop)
`define GLE_NEVER(lbl, clk, rst_n, prop)
`endif
`endif

@@ rtl/gle_pkg.sv @@
// types, constants and helpers shared by the gif lzw encoder
package gle_pkg;

    localparam int GLE_TABLE_DEPTH = 5003;
    localparam int GLE_PROBE_STEP  = 15;
    localparam int GLE_EPOCH_W     = 4;
    localparam logic [3:0]  GLE_MAX_WIDTH = 4'd12;
    localparam logic [12:0] GLE_LAST_THR  = 13'hFFF;
    localparam logic [3:0]  GLE_CFG_RESET = 4'd8;
    localparam logic [3:0]  GLE_SIZE_MIN  = 4'd2;
    localparam logic [3:0]  GLE_SIZE_MAX  = 4'd8;

    // one classified pixel on its way from front to core
    typedef struct packed {
        logic [7:0] pix;
        logic       last;
        logic       first;
        logic [3:0] lat;
    } t_item;

    // one code handed from core to packer
    typedef struct packed {
        logic [11:0] code;
        logic [3:0]  width;
        logic        eoi;
        logic        flush;
    } t_pk_req;

    function automatic logic [7:0] pix_mask(input logic [3:0] lat);
        logic [8:0] one;
        one = 9'd1 << lat;
        return 8'(one - 9'd1);
    endfunction

endpackage

@@ rtl/gle_front.sv @@
// front: config register, image start detection, code size latch, item queue
module gle_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [3:0]    i_cfg_data,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [7:0]    i_pixel_index,
    input  logic          i_last_pixel,
    output logic          o_item_valid,
    input  logic          i_item_ready,
    output gle_pkg::t_item o_item
);
    import gle_pkg::*;

    logic [3:0] r_cfg;
    logic [3:0] r_lat;
    logic       r_first;
    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;
    logic [3:0] lat_cl;
    logic [3:0] lat_sel;

    always_comb begin
        if (r_cfg < GLE_SIZE_MIN) begin
            lat_cl = GLE_SIZE_MIN;
        end else if (r_cfg > GLE_SIZE_MAX) begin
            lat_cl = GLE_SIZE_MAX;
        end else begin
            lat_cl = r_cfg;
        end
    end

    assign lat_sel      = r_first ? lat_cl : r_lat;
    assign o_in_ready   = (r_cnt != 2'd2);
    assign push         = i_in_valid && o_in_ready;
    assign o_item_valid = (r_cnt != 2'd0);
    assign pop          = o_item_valid && i_item_ready;
    assign o_item       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= GLE_CFG_RESET;
            r_lat   <= GLE_CFG_RESET;
            r_first <= 1'b1;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_cnt   <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            if (push) begin
                r_q[r_wp] <= '{pix: i_pixel_index & pix_mask(lat_sel),
                               last: i_last_pixel, first: r_first, lat: lat_sel};
                r_wp    <= ~r_wp;
                r_lat   <= lat_sel;
                r_first <= i_last_pixel;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

@@ rtl/gle_packer.sv @@
// packer: lsb-first bit accumulator and byte output register
module gle_packer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  gle_pkg::t_pk_req i_req,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_code_byte,
    output logic            o_last_of_run,
    output logic            o_end_of_image
);
    import gle_pkg::*;

    localparam logic P_IDLE  = 1'b0;
    localparam logic P_DRAIN = 1'b1;

    logic        r_state;
    logic [23:0] r_acc;
    logic [4:0]  r_cnt;
    logic        r_eoi;
    logic        r_flush;
    logic [7:0]  r_held;
    logic        r_held_v;
    logic        out_free;
    logic        byte_avail;

    assign o_req_ready = (r_state == P_IDLE);
    assign out_free    = !o_out_valid || i_out_ready;
    assign byte_avail  = (r_cnt >= 5'd8) || (r_flush && (r_cnt != 5'd0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= P_IDLE;
            r_acc          <= '0;
            r_cnt          <= '0;
            r_eoi          <= 1'b0;
            r_flush        <= 1'b0;
            r_held_v       <= 1'b0;
            o_out_valid    <= 1'b0;
        end else begin
            if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                P_IDLE: begin
                    if (i_req_valid) begin
                        r_acc   <= r_acc | ({12'd0, i_req.code} << r_cnt[2:0]);
                        r_cnt   <= r_cnt + {1'b0, i_req.width};
                        r_eoi   <= i_req.eoi;
                        r_flush <= i_req.flush;
                        r_state <= P_DRAIN;
                    end
                end
                P_DRAIN: begin
                    if (byte_avail) begin
                        // one byte stays held until it is known whether it ends the item
                        if (!r_held_v || out_free) begin
                            if (r_held_v) begin
                                o_code_byte    <= r_held;
                                o_last_of_run  <= 1'b0;
                                o_end_of_image <= 1'b0;
                                o_out_valid    <= 1'b1;
                            end
                            r_held   <= r_acc[7:0];
                            r_held_v <= 1'b1;
                            if (r_cnt >= 5'd8) begin
                                r_acc <= r_acc >> 8;
                                r_cnt <= r_cnt - 5'd8;
                            end else begin
                                r_acc <= '0;
                                r_cnt <= '0;
                            end
                        end
                    end else if (r_eoi && r_held_v) begin
                        if (out_free) begin
                            o_code_byte    <= r_held;
                            o_last_of_run  <= 1'b1;
                            o_end_of_image <= r_flush;
                            o_out_valid    <= 1'b1;
                            r_held_v       <= 1'b0;
                            r_state        <= P_IDLE;
                        end
                    end else begin
                        r_state <= P_IDLE;
                    end
                end
                default: r_state <= P_IDLE;
            endcase
        end
    end

    `include "assert_macros.svh"

    `GLE_ASSERT(a_idle_partial, i_clk, i_rst_n, (r_state == P_IDLE) |-> (r_cnt < 5'd8))
    `GLE_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= 5'd19)
    `GLE_ASSERT(a_flush_empty, i_clk, i_rst_n, ((r_state == P_IDLE) && ($past(r_state) == P_DRAIN) && $past(r_flush)) |-> ((r_cnt == 5'd0) && !r_held_v))

endmodule

@@ rtl/gle_core.sv @@
// core: hash dictionary lookup and insert, code width control, code issue
module gle_core #(
    parameter int TABLE_DEPTH = gle_pkg::GLE_TABLE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_item_valid,
    output logic             o_item_ready,
    input  gle_pkg::t_item   i_item,
    output logic             o_req_valid,
    input  logic             i_req_ready,
    output gle_pkg::t_pk_req o_req
);
    import gle_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int MW = GLE_EPOCH_W + 32;
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_X  = (AW+1)'(TABLE_DEPTH);
    localparam logic [GLE_EPOCH_W-1:0] EP_MAX = '1;

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_PROBE     = 4'd2;
    localparam logic [3:0] S_START_CLR = 4'd3;
    localparam logic [3:0] S_EMIT_PFX  = 4'd4;
    localparam logic [3:0] S_EMIT_CLR  = 4'd5;
    localparam logic [3:0] S_MARK      = 4'd6;
    localparam logic [3:0] S_LAST_PFX  = 4'd7;
    localparam logic [3:0] S_LAST_END  = 4'd8;

    logic [MW-1:0]  mem [TABLE_DEPTH];
    logic [MW-1:0]  r_rd;
    logic [3:0]     r_state;
    logic [3:0]     r_lat;
    logic [3:0]     r_width;
    logic [12:0]    r_nfc;
    logic [12:0]    r_thr;
    logic [11:0]    r_prefix;
    logic [7:0]     r_cur;
    logic           r_last;
    logic [AW-1:0]  r_h;
    logic [AW-1:0]  r_probes;
    logic [GLE_EPOCH_W-1:0] r_epoch;
    logic           r_clr_pend;

    logic [11:0]    hv;
    logic [AW-1:0]  hash0;
    logic [AW:0]    h_sum;
    logic [AW:0]    h_sub;
    logic [AW-1:0]  h_nx;
    logic [AW-1:0]  rd_addr;
    logic           wr_en;
    logic [MW-1:0]  wr_data;
    logic           ent_valid;
    logic           key_hit;
    logic [11:0]    clr_code;
    logic [12:0]    nfc_inc;
    logic [12:0]    thr2;
    logic [3:0]     next_after;
    logic [GLE_EPOCH_W-1:0] ep_nx;
    logic           pend_nx;

    // prefix and shifted pixel both fit in 12 bits, so the modulo never bites
    assign hv      = r_prefix ^ {i_item.pix, 4'b0000};
    assign hash0   = AW'(hv);
    assign h_sum   = {1'b0, r_h} + (AW+1)'(GLE_PROBE_STEP);
    assign h_sub   = h_sum - DEPTH_X;
    assign h_nx    = (h_sum >= DEPTH_X) ? h_sub[AW-1:0] : h_sum[AW-1:0];
    assign rd_addr = (r_state == S_IDLE) ? hash0 : h_nx;

    assign ent_valid = (r_rd[MW-1 -: GLE_EPOCH_W] == r_epoch);
    assign key_hit   = (r_rd[31:12] == {r_prefix, r_cur});
    assign wr_en     = (r_state == S_CLEAR) || ((r_state == S_PROBE) && !ent_valid);
    assign wr_data   = (r_state == S_CLEAR) ? '0 : {r_epoch, r_prefix, r_cur, r_nfc[11:0]};

    assign clr_code   = 12'd1 << r_lat;
    assign nfc_inc    = r_nfc + 13'd1;
    assign thr2       = ({r_thr[11:0], 1'b0} > GLE_LAST_THR) ? GLE_LAST_THR
                                                             : {r_thr[11:0], 1'b0};
    assign next_after = r_last ? S_LAST_PFX : S_IDLE;
    assign ep_nx      = (r_epoch == EP_MAX) ? GLE_EPOCH_W'(1) : r_epoch + GLE_EPOCH_W'(1);
    assign pend_nx    = r_clr_pend || (r_epoch == EP_MAX);

    assign o_item_ready = (r_state == S_IDLE) && !r_clr_pend;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_h] <= wr_data;
        end
        r_rd <= mem[rd_addr];
    end

    always_comb begin
        o_req_valid = 1'b1;
        o_req       = '{code: clr_code, width: r_width, eoi: !r_last, flush: 1'b0};
        unique case (r_state)
            S_START_CLR, S_EMIT_CLR: begin
            end
            S_EMIT_PFX: begin
                o_req.code = r_prefix;
                o_req.eoi  = !r_last && !((nfc_inc > r_thr) && (r_width >= GLE_MAX_WIDTH));
            end
            S_MARK: begin
                o_req.code  = '0;
                o_req.width = '0;
                o_req.eoi   = 1'b1;
            end
            S_LAST_PFX: begin
                o_req.code = r_prefix;
                o_req.eoi  = 1'b0;
            end
            S_LAST_END: begin
                o_req.code  = clr_code + 12'd1;
                o_req.eoi   = 1'b1;
                o_req.flush = 1'b1;
            end
            default: o_req_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_h        <= '0;
            r_epoch    <= '0;
            r_clr_pend <= 1'b0;
            r_width    <= '0;
            r_nfc      <= '0;
            r_thr      <= '0;
            r_lat      <= GLE_CFG_RESET;
            r_prefix   <= '0;
            r_probes   <= '0;
            r_last     <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_h <= r_h + AW'(1);
                    if (r_h == LAST_IDX) begin
                        r_clr_pend <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (r_clr_pend) begin
                        r_h     <= '0;
                        r_state <= S_CLEAR;
                    end else if (i_item_valid) begin
                        r_cur    <= i_item.pix;
                        r_last   <= i_item.last;
                        r_probes <= '0;
                        if (i_item.first) begin
                            r_lat      <= i_item.lat;
                            r_width    <= i_item.lat + 4'd1;
                            r_nfc      <= (13'd1 << i_item.lat) + 13'd2;
                            r_thr      <= 13'd1 << (i_item.lat + 4'd1);
                            r_prefix   <= {4'b0000, i_item.pix};
                            r_epoch    <= ep_nx;
                            r_clr_pend <= pend_nx;
                            r_state    <= S_START_CLR;
                        end else begin
                            r_h     <= hash0;
                            r_state <= S_PROBE;
                        end
                    end
                end
                S_PROBE: begin
                    priority if (!ent_valid) begin
                        r_state <= S_EMIT_PFX;
                    end else if (key_hit) begin
                        r_prefix <= r_rd[11:0];
                        r_state  <= r_last ? S_LAST_PFX : S_MARK;
                    end else if (r_probes == LAST_IDX) begin
                        r_state <= S_EMIT_PFX;
                    end else begin
                        r_h      <= h_nx;
                        r_probes <= r_probes + AW'(1);
                    end
                end
                S_START_CLR: begin
                    if (i_req_ready) begin
                        r_state <= next_after;
                    end
                end
                S_EMIT_PFX: begin
                    if (i_req_ready) begin
                        r_nfc    <= nfc_inc;
                        r_prefix <= {4'b0000, r_cur};
                        if ((nfc_inc > r_thr) && (r_width >= GLE_MAX_WIDTH)) begin
                            r_state <= S_EMIT_CLR;
                        end else begin
                            if (nfc_inc > r_thr) begin
                                r_thr   <= thr2;
                                r_width <= r_width + 4'd1;
                            end
                            r_state <= next_after;
                        end
                    end
                end
                S_EMIT_CLR: begin
                    if (i_req_ready) begin
                        r_width    <= r_lat + 4'd1;
                        r_nfc      <= (13'd1 << r_lat) + 13'd2;
                        r_thr      <= 13'd1 << (r_lat + 4'd1);
                        r_epoch    <= ep_nx;
                        r_clr_pend <= pend_nx;
                        r_state    <= next_after;
                    end
                end
                S_MARK: begin
                    if (i_req_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                S_LAST_PFX: begin
                    if (i_req_ready) begin
                        if ((r_nfc == r_thr) && (r_width < GLE_MAX_WIDTH)) begin
                            r_width <= r_width + 4'd1;
                        end
                        r_state <= S_LAST_END;
                    end
                end
                S_LAST_END: begin
                    if (i_req_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `include "assert_macros.svh"

    `GLE_ASSERT(a_width_cap, i_clk, i_rst_n, r_width <= GLE_MAX_WIDTH)
    `GLE_ASSERT(a_nfc_cap, i_clk, i_rst_n, r_nfc <= 13'd4096)
    `GLE_NEVER(a_pop_in_sweep, i_clk, i_rst_n, o_item_ready && (r_clr_pend || (r_state == S_CLEAR)))
    `GLE_ASSERT(a_probe_idle, i_clk, i_rst_n, (r_state == S_PROBE) |-> !o_req_valid)

endmodule

@@ rtl/gif_lzw_encoder.sv @@
// gif lzw encoder top level: front queue, dictionary core and byte packer
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  pixel in | i_in_valid / o_in_ready    | i_pixel_index, i_last_pixel
//  bytes out| o_out_valid / i_out_ready  | o_code_byte, o_last_of_run, o_end_of_image
//  config   | i_cfg_we                   | i_cfg_data (min code size)
//
// a pixel found in the dictionary is handled in the probe loop, one memory read per probe
// a new string sends its prefix code plus any extra code, and each code waits for the
// packer, which takes no new code until it has drained the bytes of the last one
// after reset, and when the epoch counter wraps, a clear sweep of all TABLE_DEPTH entries
// runs before the next pixel is taken; the 2-entry queue lets input and output stall apart
module gif_lzw_encoder #(
    parameter int TABLE_DEPTH = gle_pkg::GLE_TABLE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_pixel_index,
    input  logic       i_last_pixel,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_code_byte,
    output logic       o_last_of_run,
    output logic       o_end_of_image
);
    import gle_pkg::*;

    t_item   item;
    logic    item_valid;
    logic    item_ready;
    t_pk_req req;
    logic    req_valid;
    logic    req_ready;

    gle_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_pixel_index(i_pixel_index),
        .i_last_pixel (i_last_pixel),
        .o_item_valid (item_valid),
        .i_item_ready (item_ready),
        .o_item       (item)
    );

    gle_core #(.TABLE_DEPTH(TABLE_DEPTH)) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item_valid(item_valid),
        .o_item_ready(item_ready),
        .i_item      (item),
        .o_req_valid (req_valid),
        .i_req_ready (req_ready),
        .o_req       (req)
    );

    gle_packer u_packer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (req_valid),
        .o_req_ready   (req_ready),
        .i_req         (req),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_code_byte   (o_code_byte),
        .o_last_of_run (o_last_of_run),
        .o_end_of_image(o_end_of_image)
    );

endmodule
